// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/afnl_pkg.sv =====
// ---------------------------------------------------------------------------
// afnl_pkg
// Types and constants of the actuator force norm limiter.
// ---------------------------------------------------------------------------
package afnl_pkg;

  localparam int MAX_DOF       = 6;
  localparam int DOF_COUNT_DEF = 6;
  localparam int SIG_W         = 16;
  localparam int LIM_W         = 16;
  localparam int F_W           = 16;
  localparam int SQ_W          = 31;
  localparam int PAIR_W        = 32;
  localparam int RAD_W         = 34;
  localparam int ROOT_W        = 17;
  localparam int REM_W         = 21;
  localparam int MF_W          = 17;
  localparam int N_W           = F_W + MF_W;
  localparam int Q_W           = 16;
  localparam int DREM_W        = N_W - Q_W;
  localparam int SQ_PER        = 2;
  localparam int NSQ           = (ROOT_W + SQ_PER - 1) / SQ_PER;
  localparam int DIV_PER       = 2;
  localparam int NDIV          = Q_W / DIV_PER;
  localparam int LANE_LAT      = 2;
  localparam int MERGE_LAT     = 2 + NSQ;
  localparam int DIV_LAT       = 1 + NDIV;
  localparam int OFIFO_DEPTH   = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE = CFG_IDX_W'(MAX_DOF);
  localparam logic [MF_W-1:0]      MF_RESET      = '1;

  typedef struct packed {
    logic signed [SIG_W-1:0] signal_0;
    logic signed [SIG_W-1:0] signal_1;
    logic signed [SIG_W-1:0] signal_2;
    logic signed [SIG_W-1:0] signal_3;
    logic signed [SIG_W-1:0] signal_4;
    logic signed [SIG_W-1:0] signal_5;
  } signal_word_t;

  typedef struct packed {
    logic signed [F_W-1:0] force_0;
    logic signed [F_W-1:0] force_1;
    logic signed [F_W-1:0] force_2;
    logic signed [F_W-1:0] force_3;
    logic signed [F_W-1:0] force_4;
    logic signed [F_W-1:0] force_5;
    logic                  was_scaled;
  } force_word_t;

  // Per-DOF force as sign and magnitude (magnitude up to 2^15).
  typedef struct packed {
    logic           neg;
    logic [F_W-1:0] mag;
  } lane_t;

endpackage

// ===== rtl/afnl_lane.sv =====
// ---------------------------------------------------------------------------
// afnl_lane
// One DOF: limit select, scale by signal magnitude, then square.
// ---------------------------------------------------------------------------
module afnl_lane import afnl_pkg::*; (
  input  logic                    clk,
  input  logic signed [SIG_W-1:0] sig,
  input  logic [CFG_W-1:0]        limits,
  output lane_t                   lane,
  output logic [SQ_W-1:0]         sq
);

  logic             s_neg;
  logic             s_pos;
  logic [SIG_W-1:0] s_mag;
  logic [LIM_W-1:0] raw;
  logic             l_neg;
  logic [LIM_W-1:0] l_mag;
  logic [SIG_W+LIM_W-1:0] prod;
  logic [F_W-1:0]   f;
  logic [2*F_W-1:0] f_sq;

  lane_t l1;
  lane_t l2;
  logic [SQ_W-1:0] sq2;

  always_comb begin
    s_neg = sig[SIG_W-1];
    s_mag = s_neg ? (SIG_W'(0) - SIG_W'(sig)) : SIG_W'(sig);
    s_pos = !s_neg && (sig != '0);
    raw   = s_pos ? limits[CFG_W-1 -: LIM_W] : limits[LIM_W-1:0];
    l_neg = raw[LIM_W-1];
    l_mag = l_neg ? (LIM_W'(0) - raw) : raw;
    prod  = {{LIM_W{1'b0}}, s_mag} * {{SIG_W{1'b0}}, l_mag};
    f     = prod[SIG_W-1 +: F_W];
    f_sq  = {{F_W{1'b0}}, l1.mag} * {{F_W{1'b0}}, l1.mag};
  end

  always_ff @(posedge clk) begin
    l1.mag <= f;
    l1.neg <= l_neg && (f != '0);
    l2     <= l1;
    sq2    <= f_sq[SQ_W-1:0];
  end

  assign lane = l2;
  assign sq   = sq2;

endmodule

// ===== rtl/afnl_merge.sv =====
// ---------------------------------------------------------------------------
// afnl_merge
// Sum of squares over the lanes and pipelined integer square root.
// ---------------------------------------------------------------------------
module afnl_merge import afnl_pkg::*; (
  input  logic                            clk,
  input  logic [MAX_DOF-1:0][SQ_W-1:0]    sq,
  input  lane_t [MAX_DOF-1:0]             lanes_in,
  output logic [ROOT_W-1:0]               norm,
  output lane_t [MAX_DOF-1:0]             lanes_out
);

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // One bit of the root per radix-4 digit (bit pair) of the radicand.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    sqrt_st_t o;
    r     = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [PAIR_W-1:0] pair [3];
  sqrt_st_t st [NSQ+1];
  lane_t [MAX_DOF-1:0] lane_d [MERGE_LAT];

  always_ff @(posedge clk) begin
    pair[0] <= {1'b0, sq[0]} + {1'b0, sq[1]};
    pair[1] <= {1'b0, sq[2]} + {1'b0, sq[3]};
    pair[2] <= {1'b0, sq[4]} + {1'b0, sq[5]};
    st[0].rad  <= {2'b00, pair[0]} + {2'b00, pair[1]} + {2'b00, pair[2]};
    st[0].rem  <= '0;
    st[0].root <= '0;
    lane_d[0]  <= lanes_in;
    for (int i = 1; i < MERGE_LAT; i++) begin
      lane_d[i] <= lane_d[i-1];
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    sqrt_st_t cur;
    always_comb begin
      cur = st[k];
      for (int t = 0; t < SQ_PER; t++) begin
        if (k * SQ_PER + t < ROOT_W) begin
          cur = sqrt_step(cur);
        end
      end
    end
    always_ff @(posedge clk) begin
      st[k+1] <= cur;
    end
  end

  assign norm      = st[NSQ].root;
  assign lanes_out = lane_d[MERGE_LAT-1];

endmodule

// ===== rtl/afnl_div.sv =====
// ---------------------------------------------------------------------------
// afnl_div
// Per-lane rescale: force * max_force / norm when norm > max_force, else force as is; pipelined restoring divide.
// ---------------------------------------------------------------------------
module afnl_div import afnl_pkg::*; (
  input  logic                  clk,
  input  lane_t                 lane_in,
  input  logic [ROOT_W-1:0]     norm,
  input  logic [MF_W-1:0]       max_force,
  output logic signed [F_W-1:0] force_val,
  output logic                  scaled
);

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [Q_W-1:0]    low;
    logic [Q_W-1:0]    q;
  } div_st_t;

  // One quotient bit; the quotient fits in Q_W bits whenever scaling applies.
  function automatic div_st_t div_step(input div_st_t s, input logic [ROOT_W-1:0] d);
    logic [DREM_W:0] r;
    div_st_t o;
    r     = {s.rem, s.low[Q_W-1]};
    o.low = {s.low[Q_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r   = r - {1'b0, d};
      o.q = {s.q[Q_W-2:0], 1'b1};
    end else begin
      o.q = {s.q[Q_W-2:0], 1'b0};
    end
    o.rem = r[DREM_W-1:0];
    return o;
  endfunction

  logic [N_W-1:0]    num;
  div_st_t           st [NDIV+1];
  logic [ROOT_W-1:0] den [NDIV+1];
  lane_t             lane_d [NDIV+1];
  logic              scale_d [NDIV+1];
  logic [F_W-1:0]    mag;

  assign num = {{MF_W{1'b0}}, lane_in.mag} * {{F_W{1'b0}}, max_force};

  always_ff @(posedge clk) begin
    st[0].rem  <= num[N_W-1 -: DREM_W];
    st[0].low  <= num[Q_W-1:0];
    st[0].q    <= '0;
    den[0]     <= norm;
    lane_d[0]  <= lane_in;
    scale_d[0] <= norm > {{(ROOT_W-MF_W){1'b0}}, max_force};
    for (int i = 1; i <= NDIV; i++) begin
      den[i]     <= den[i-1];
      lane_d[i]  <= lane_d[i-1];
      scale_d[i] <= scale_d[i-1];
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    div_st_t cur;
    always_comb begin
      cur = st[k];
      for (int t = 0; t < DIV_PER; t++) begin
        cur = div_step(cur, den[k]);
      end
    end
    always_ff @(posedge clk) begin
      st[k+1] <= cur;
    end
  end

  always_comb begin
    mag       = scale_d[NDIV] ? st[NDIV].q : lane_d[NDIV].mag;
    force_val = (lane_d[NDIV].neg && mag != '0) ? $signed(F_W'(0) - mag) : $signed(mag);
  end

  assign scaled = scale_d[NDIV];

endmodule

// ===== rtl/afnl_ofifo.sv =====
// ---------------------------------------------------------------------------
// afnl_ofifo
// Result word queue that decouples the pipeline from the output stall.
// ---------------------------------------------------------------------------
module afnl_ofifo import afnl_pkg::*; #(
  parameter int DEPTH = OFIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  force_word_t wr_data,
  input  logic        rd_en,
  output logic        rd_valid,
  output force_word_t rd_data
);

  localparam int AW = $clog2(DEPTH);

  force_word_t     mem [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en && rd_valid) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (wr_en ? (AW+1)'(1) : '0) - ((rd_en && rd_valid) ? (AW+1)'(1) : '0);
    end
  end

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];

endmodule

// ===== rtl/actuator_force_norm_limiter_unit.sv =====
// ---------------------------------------------------------------------------
// actuator_force_norm_limiter_unit
// Limit-scaled force vector with Euclidean norm clamp to max_force.
// ---------------------------------------------------------------------------
// Path: 2 lane, 11 norm and 9 rescale register stages, then the result queue
//   write, lie between an accepted word and force_valid.
// Throughput: one word per cycle unless stalled; the 32-entry result queue
//   bounds words in flight, so signal_stall rises only when the output holds back.
// Reset (rst, synchronous): limits clear to 0, max_force to all ones, the
//   pipeline and the queue empty.
module actuator_force_norm_limiter_unit import afnl_pkg::*; #(
  parameter int DOF_COUNT = DOF_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 signal_valid,
  output logic                 signal_stall,
  input  signal_word_t         signals,
  output logic                 force_valid,
  input  logic                 force_stall,
  output force_word_t          forces,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "assert_macros.svh"

  localparam int LAT   = LANE_LAT + MERGE_LAT + DIV_LAT;
  localparam int OCC_W = $clog2(OFIFO_DEPTH + 1);

  // Configuration registers
  logic [CFG_W-1:0] limits [MAX_DOF];
  logic [MF_W-1:0]  max_force;

  // Valid line alongside the datapath, words in flight plus queued
  logic [LAT-1:0]   vld;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;
  logic             acc_in;
  logic             acc_out;

  logic signed [SIG_W-1:0]       sig_arr [MAX_DOF];
  logic [MAX_DOF-1:0][SQ_W-1:0]  sq;
  lane_t [MAX_DOF-1:0]           lanes;
  lane_t [MAX_DOF-1:0]           lanes_m;
  logic [ROOT_W-1:0]             norm;
  logic signed [F_W-1:0]         frc [MAX_DOF];
  logic [MAX_DOF-1:0]            scaled;
  force_word_t                   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DOF; i++) begin
        limits[i] <= '0;
      end
      max_force <= MF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // Indices past max_force are dropped
      if (cfg_index < CFG_MAX_FORCE) begin
        limits[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_MAX_FORCE) begin
        max_force <= cfg_data[MF_W-1:0];
      end
    end
  end

  assign acc_in  = signal_valid && !signal_stall;
  assign acc_out = force_valid && !force_stall;

  // Admit a word only when the queue is sure to have room for it
  assign signal_stall = (occ == OCC_W'(OFIFO_DEPTH));
  assign occ_next = occ + (acc_in ? OCC_W'(1) : '0) - (acc_out ? OCC_W'(1) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      occ <= '0;
    end else begin
      vld <= {vld[LAT-2:0], acc_in};
      occ <= occ_next;
    end
  end

  assign sig_arr[0] = signals.signal_0;
  assign sig_arr[1] = signals.signal_1;
  assign sig_arr[2] = signals.signal_2;
  assign sig_arr[3] = signals.signal_3;
  assign sig_arr[4] = signals.signal_4;
  assign sig_arr[5] = signals.signal_5;

  // Lanes: one per active DOF; unused DOFs contribute nothing and read 0
  for (genvar i = 0; i < MAX_DOF; i++) begin : g_lane
    if (i < DOF_COUNT) begin : g_on
      afnl_lane u_lane (
        .clk    (clk),
        .sig    (sig_arr[i]),
        .limits (limits[i]),
        .lane   (lanes[i]),
        .sq     (sq[i])
      );
    end else begin : g_off
      assign lanes[i] = '0;
      assign sq[i]    = '0;
    end
  end

  // Merge: sum of squares and floor square root
  afnl_merge u_merge (
    .clk       (clk),
    .sq        (sq),
    .lanes_in  (lanes),
    .norm      (norm),
    .lanes_out (lanes_m)
  );

  // Rescale per lane against the shared norm
  for (genvar i = 0; i < MAX_DOF; i++) begin : g_div
    if (i < DOF_COUNT) begin : g_on
      afnl_div u_div (
        .clk       (clk),
        .lane_in   (lanes_m[i]),
        .norm      (norm),
        .max_force (max_force),
        .force_val (frc[i]),
        .scaled    (scaled[i])
      );
    end else begin : g_off
      assign frc[i]    = '0;
      assign scaled[i] = 1'b0;
    end
  end

  always_comb begin
    result.force_0    = frc[0];
    result.force_1    = frc[1];
    result.force_2    = frc[2];
    result.force_3    = frc[3];
    result.force_4    = frc[4];
    result.force_5    = frc[5];
    // Every active lane carries the same flag; lane 0 is always active
    result.was_scaled = scaled[0];
  end

  afnl_ofifo #(
    .DEPTH (OFIFO_DEPTH)
  ) u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (vld[LAT-1]),
    .wr_data  (result),
    .rd_en    (!force_stall),
    .rd_valid (force_valid),
    .rd_data  (forces)
  );

  `ASSERT_ALWAYS(a_occ_bound, occ <= OCC_W'(OFIFO_DEPTH), "words in flight exceed queue depth")
  `ASSERT_ALWAYS(a_valid_has_word, !force_valid || occ != '0, "output valid with nothing in flight")
  `ASSERT_NEXT(a_occ_inc, acc_in && !acc_out, occ == $past(occ) + OCC_W'(1), "in-flight count did not grow")

endmodule

// ===== bench/afnl_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afnl_checker
// Watches the signal, force and config channels, predicts each force word
// from its own copy of the limits and max_force, and compares in order.
// ---------------------------------------------------------------------------
module afnl_checker import afnl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 signal_valid,
  input  logic                 signal_stall,
  input  signal_word_t         signals,
  input  logic                 force_valid,
  input  logic                 force_stall,
  input  force_word_t          forces,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [CFG_W-1:0] lim_copy [MAX_DOF];
  logic [MF_W-1:0]  mf_copy;
  force_word_t      want_q[$];

  assign pending = want_q.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= root + bit_v) begin
        v -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic force_word_t limit_forces(input signal_word_t s);
    logic [15:0] sig [MAX_DOF];
    logic [63:0] mag [MAX_DOF];
    logic        neg [MAX_DOF];
    logic [63:0] smag, lmag, sumsq, norm, f;
    logic [15:0] raw, v [MAX_DOF];
    logic        scale;
    force_word_t r;
    sig = '{s.signal_0, s.signal_1, s.signal_2, s.signal_3, s.signal_4, s.signal_5};
    sumsq = 0;
    for (int i = 0; i < MAX_DOF; i++) begin
      smag = sig[i][15] ? (64'h10000 - sig[i]) : sig[i];
      raw = (!sig[i][15] && sig[i] != 0) ? lim_copy[i][31:16] : lim_copy[i][15:0];
      lmag = raw[15] ? (64'h10000 - raw) : raw;
      mag[i] = (smag * lmag) >> 15;
      neg[i] = raw[15] && mag[i] != 0;
      sumsq += mag[i] * mag[i];
    end
    norm = int_sqrt(sumsq);
    scale = norm > mf_copy;
    for (int i = 0; i < MAX_DOF; i++) begin
      f = scale ? (mag[i] * mf_copy) / norm : mag[i];
      v[i] = (neg[i] && f != 0) ? 16'(64'h10000 - f) : f[15:0];
    end
    r = '{v[0], v[1], v[2], v[3], v[4], v[5], scale};
    return r;
  endfunction

  task automatic report(input string what, input logic [15:0] got, want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    force_word_t w;
    if (rst) begin
      foreach (lim_copy[i]) lim_copy[i] <= '0;
      mf_copy <= MF_RESET;
      want_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < CFG_MAX_FORCE) lim_copy[cfg_index] <= cfg_data;
        else if (cfg_index == CFG_MAX_FORCE) mf_copy <= cfg_data[MF_W-1:0];
      end
      if (signal_valid && !signal_stall) want_q = {want_q, limit_forces(signals)};
      if (force_valid && !force_stall) begin
        if (want_q.size() == 0) begin
          $display("unexpected force word at %0t", $realtime);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          if (forces.force_0 !== w.force_0) report("force_0", forces.force_0, w.force_0);
          if (forces.force_1 !== w.force_1) report("force_1", forces.force_1, w.force_1);
          if (forces.force_2 !== w.force_2) report("force_2", forces.force_2, w.force_2);
          if (forces.force_3 !== w.force_3) report("force_3", forces.force_3, w.force_3);
          if (forces.force_4 !== w.force_4) report("force_4", forces.force_4, w.force_4);
          if (forces.force_5 !== w.force_5) report("force_5", forces.force_5, w.force_5);
          if (forces.was_scaled !== w.was_scaled)
            report("was_scaled", 16'(forces.was_scaled), 16'(w.was_scaled));
        end
      end
    end
  end

endmodule

// ===== bench/tb_actuator_force_norm_limiter_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_actuator_force_norm_limiter_unit
// Drives signal words and limit settings into the limiter with random gaps
// and output stalls; the checker predicts and compares each force word.
// ---------------------------------------------------------------------------
module tb_actuator_force_norm_limiter_unit;
  import afnl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;   // longer than the pipeline

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 signal_valid = 0;
  logic                 signal_stall;
  signal_word_t         signals = '0;
  logic                 force_valid;
  logic                 force_stall = 0;
  force_word_t          forces;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count, pending, cycles;
  bit                   sink_calm;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  actuator_force_norm_limiter_unit dut (.*);

  afnl_checker chk (.*);

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output side: random stall per word, calm stretches when sink_calm is set.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = sink_calm ? 0 : $urandom_range(0, 17);
      if (n != 0) begin
        force_stall <= 1;
        repeat (n) @(negedge clk);
      end
      force_stall <= 0;
      @(posedge clk);
      while (!force_valid) @(posedge clk);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Waits for every expected word, then for the pipeline to empty.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Sends one word, with a random gap unless calm.
  task automatic send(input signal_word_t w, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap != 0) begin
      signal_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    signal_valid <= 1;
    signals <= w;
    @(posedge clk);
    while (signal_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    signal_valid <= 0;
  endtask

  function automatic logic [15:0] rand_sig();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 3)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic signal_word_t rand_word();
    signal_word_t w;
    w = '{rand_sig(), rand_sig(), rand_sig(), rand_sig(), rand_sig(), rand_sig()};
    return w;
  endfunction

  // Limits: extremes, min above max, random.
  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_8000;
      1: return 32'h8000_7fff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_max_force();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'h1ffff;
      2: return 32'($urandom_range(1, 200));
      default: return 32'($urandom_range(0, 80000)) | 32'($urandom & 32'hfffe_0000);
    endcase
  endfunction

  initial begin
    signal_word_t w;
    bit calm;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: reset limits give zero forces.
    send('{16'h8000, 16'h7fff, 16'h0, 16'h1, 16'hffff, 16'h4000}, 0);
    end_burst();
    drain();
    // Full-scale limits, min above max on two DOFs, out-of-range index ignored.
    write_reg(CFG_IDX_W'(0), 32'h7fff_8000);
    write_reg(CFG_IDX_W'(1), 32'h8000_7fff);
    write_reg(CFG_IDX_W'(2), 32'h4000_c000);
    write_reg(CFG_IDX_W'(3), 32'h1000_2000);
    write_reg(CFG_IDX_W'(4), 32'h0001_ffff);
    write_reg(CFG_IDX_W'(5), 32'h7fff_7fff);
    write_reg(CFG_IDX_W'(7), 32'hdead_beef);
    w = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    send(w, 0);
    send('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 0);
    send('{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 0);
    send('{16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001}, 0);
    send('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa}, 0);
    end_burst();
    drain();
    // Norm just below the limit: one DOF forces 32766.
    write_reg(CFG_IDX_W'(0), 32'h7fff_0000);
    write_reg(CFG_IDX_W'(1), 32'd0);
    write_reg(CFG_IDX_W'(2), 32'd0);
    write_reg(CFG_IDX_W'(3), 32'd0);
    write_reg(CFG_IDX_W'(4), 32'd0);
    write_reg(CFG_IDX_W'(5), 32'd0);
    write_reg(CFG_MAX_FORCE, 32'd32767);
    send('{16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 0);
    end_burst();
    drain();
    write_reg(CFG_MAX_FORCE, 32'd32766);
    send('{16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 0);
    end_burst();
    drain();
    write_reg(CFG_MAX_FORCE, 32'd0);
    send('{16'h7fff, 16'h8000, 16'h1234, 16'h0, 16'h0, 16'h0}, 0);
    end_burst();
    drain();

    // Random phases, each with a new setting.
    for (int ph = 0; ph < 24; ph++) begin
      for (int r = 0; r < MAX_DOF; r++) write_reg(CFG_IDX_W'(r), rand_limit());
      write_reg(CFG_MAX_FORCE, rand_max_force());
      calm = (ph % 4 == 1);
      sink_calm = (ph % 4 == 1);
      for (int k = 0; k < 60; k++) send(rand_word(), calm);
      end_burst();
      drain();
    end
    sink_calm = 0;

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
